@@ hdl/refcounted_palette_slot_allocator_defines.svh @@
// Assertion macros shared by the checker of the palette slot allocator.
// No dependencies; the file that asserts includes it by name.
`ifndef REFCOUNTED_PALETTE_SLOT_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PALETTE_SLOT_ALLOCATOR_DEFINES_SVH

// Checked at every edge outside reset.
`define RPSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define RPSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rpsa_pkg.sv @@
// Types and constants of the palette slot allocator.
// No dependencies; used by every module of the block but rpsa_fifo.
`timescale 1ns / 1ps
package rpsa_pkg;

  typedef enum logic [2:0] {
    OP_CRES  = 3'd0,
    OP_CREL  = 3'd1,
    OP_STAGE = 3'd2,
    OP_GRES  = 3'd3,
    OP_GREL  = 3'd4
  } op_t;

  localparam logic [1:0] KIND_COLOR = 2'd0;
  localparam logic [1:0] KIND_GROUP = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [15:0] SCOUNT_MAX = 16'hFFFF;
  localparam logic [7:0]  GCOUNT_MAX = 8'hFF;
  localparam logic [3:0]  WORD_LAST  = 4'd15;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] color;
    logic [3:0]  position;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [7:0]  index;
    logic [15:0] data;
    logic        last;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] color;
    logic [3:0]  pos;
  } cmd_t;

endpackage

@@ hdl/rpsa_fifo.sv @@
// Two-entry queue of W-bit words with push/full and pop/empty handshakes.
// No dependencies.
`timescale 1ns / 1ps
module rpsa_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wp_r] <= wdata;
        wp_r        <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end
endmodule

@@ hdl/rpsa_front.sv @@
// Front end: accepts input transactions, drops those that do nothing and
// queues the rest as commands. Depends on rpsa_pkg and rpsa_fifo.
`timescale 1ns / 1ps
module rpsa_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpsa_pkg::in_t in_item,
  output logic          full,
  input  logic          cmd_pop,
  output rpsa_pkg::cmd_t cmd,
  output logic          cmd_empty
);
  import rpsa_pkg::*;

  logic cmd_valid;
  cmd_t cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // Undefined function codes and staging at position zero have no effect.
  always_comb begin
    cmd_valid = 1'b0;
    if (in_item.func inside {[3'd0:3'd4]}) begin
      cmd_valid = !((in_item.func == OP_STAGE) && (in_item.position == 4'd0));
    end
    cmd_in.op    = op_t'(in_item.func);
    cmd_in.color = in_item.color;
    cmd_in.pos   = in_item.position;
  end

  rpsa_fifo #(.W($bits(cmd_t))) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && cmd_valid),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);
endmodule

@@ hdl/rpsa_back.sv @@
// Back end: carries out commands against the slot, count and palette state
// and emits results. Depends on rpsa_pkg.
`timescale 1ns / 1ps
module rpsa_back #(
  parameter int NUM_ROWS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  rpsa_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output rpsa_pkg::out_t res_item
);
  import rpsa_pkg::*;

  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam logic [RW-1:0] ROW_LAST = RW'(NUM_ROWS - 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CRD   = 13'b0000000000010,
    S_CCMP  = 13'b0000000000100,
    S_KRD   = 13'b0000000001000,
    S_KUPD  = 13'b0000000010000,
    S_CWR   = 13'b0000000100000,
    S_CANS  = 13'b0000001000000,
    S_GCHK  = 13'b0000010000000,
    S_GRD   = 13'b0000100000000,
    S_GCMP  = 13'b0001000000000,
    S_GFREE = 13'b0010000000000,
    S_GWR   = 13'b0100000000000,
    S_GANS  = 13'b1000000000000
  } state_t;

  state_t        st_r;
  op_t           op_r;
  logic [15:0]   color_r;
  logic [7:0]    slot_r, idx_r, free_idx_r;
  logic          free_vld_r, ok_r;
  logic [15:0]   wdat_r;
  logic [RW-1:0] row_r;
  logic [3:0]    j_r;
  logic [6:0]    c_r;
  logic [19:0]   sum_r;
  logic [255:0]  used_r, single_r;
  logic [6:0]    gchk_r [NUM_ROWS];
  logic [7:0]    gcnt_r [NUM_ROWS];
  logic [15:0]   staged_r [15];

  logic [15:0] pal_mem [256];
  logic [15:0] cnt_mem [256];
  logic [15:0] pal_rd_r, cnt_rd_r;
  logic        pal_we, cnt_we;
  logic [7:0]  pal_wa, pal_ra;
  logic [15:0] pal_wd, cnt_wd;

  logic [7:0]  gaddr, gbase;
  logic [3:0]  stg_idx;
  logic [15:0] gdat;
  logic [6:0]  chk_raw, chk;
  logic [15:0] cupd;
  logic [7:0]  gupd;
  logic        emit, fire;

  assign gaddr   = {4'(row_r), j_r};
  assign gbase   = {4'(row_r), 4'd1};
  assign stg_idx = j_r - 4'd1;
  assign gdat    = (op_r == OP_GRES) ? staged_r[stg_idx] : 16'd0;
  assign chk_raw = sum_r[12:6];
  // A zero checksum is bumped to one so that an empty row never matches.
  assign chk     = (chk_raw == 7'd0) ? 7'd1 : chk_raw;
  assign cupd    = (op_r == OP_CRES) ?
                   ((cnt_rd_r == SCOUNT_MAX) ? SCOUNT_MAX : cnt_rd_r + 16'd1) :
                   cnt_rd_r - 16'd1;
  assign gupd    = (op_r == OP_GRES) ?
                   ((gcnt_r[row_r] == GCOUNT_MAX) ? GCOUNT_MAX : gcnt_r[row_r] + 8'd1) :
                   gcnt_r[row_r] - 8'd1;
  assign cmd_pop = (st_r == S_IDLE) && !cmd_empty;

  always_comb begin
    emit     = 1'b0;
    res_item = '0;
    case (st_r)
      S_CWR: begin
        emit     = 1'b1;
        res_item = '{KIND_WRITE, 1'b0, idx_r, wdat_r, op_r == OP_CREL};
      end
      S_CANS: begin
        emit     = 1'b1;
        res_item = '{KIND_COLOR, ok_r, idx_r, 16'd0, 1'b1};
      end
      S_GWR: begin
        emit     = 1'b1;
        res_item = '{KIND_WRITE, 1'b0, gaddr, gdat,
                     (op_r == OP_GREL) && (j_r == WORD_LAST)};
      end
      S_GANS: begin
        emit     = 1'b1;
        res_item = '{KIND_GROUP, ok_r, ok_r ? 8'(row_r) : 8'd0, 16'd0, 1'b1};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    fire     = emit && !res_full;
    res_push = fire;
  end

  always_comb begin
    pal_we = fire && ((st_r == S_CWR) || (st_r == S_GWR));
    pal_wa = (st_r == S_GWR) ? gaddr : idx_r;
    pal_wd = (st_r == S_GWR) ? gdat : wdat_r;
    pal_ra = (st_r == S_GRD) ? gaddr : slot_r;
    cnt_we = (st_r == S_KUPD) || (fire && (st_r == S_CWR) && (op_r == OP_CRES));
    cnt_wd = (st_r == S_KUPD) ? cupd : 16'd1;
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_wa] <= pal_wd;
    end
    pal_rd_r <= pal_mem[pal_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[idx_r] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      used_r   <= 256'd1;
      single_r <= '0;
      sum_r    <= '0;
      // The running sum assumes every staged word starts at zero.
      for (int i = 0; i < 15; i++) begin
        staged_r[i] <= '0;
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
        gchk_r[r] <= '0;
        gcnt_r[r] <= '0;
      end
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            op_r       <= cmd.op;
            color_r    <= cmd.color;
            slot_r     <= 8'd0;
            free_vld_r <= 1'b0;
            row_r      <= '0;
            c_r        <= chk;
            case (cmd.op)
              OP_STAGE: begin
                staged_r[cmd.pos - 4'd1] <= cmd.color;
                // Keep the running sum of the staged words current.
                sum_r <= sum_r - 20'(staged_r[cmd.pos - 4'd1]) + 20'(cmd.color);
              end
              OP_CRES, OP_CREL: st_r <= S_CRD;
              OP_GRES, OP_GREL: st_r <= S_GCHK;
              default: st_r <= S_IDLE;
            endcase
          end
        end
        S_CRD: begin
          if (!free_vld_r && !used_r[slot_r]) begin
            free_vld_r <= 1'b1;
            free_idx_r <= slot_r;
          end
          st_r <= S_CCMP;
        end
        S_CCMP: begin
          if (single_r[slot_r] && (pal_rd_r == color_r)) begin
            idx_r <= slot_r;
            st_r  <= S_KRD;
          end else if (slot_r == 8'hFF) begin
            if (op_r == OP_CREL) begin
              st_r <= S_IDLE;
            end else if (free_vld_r) begin
              idx_r  <= free_idx_r;
              wdat_r <= color_r;
              st_r   <= S_CWR;
            end else begin
              ok_r  <= 1'b0;
              idx_r <= 8'd0;
              st_r  <= S_CANS;
            end
          end else begin
            slot_r <= slot_r + 8'd1;
            st_r   <= S_CRD;
          end
        end
        S_KRD: st_r <= S_KUPD;
        S_KUPD: begin
          if (op_r == OP_CRES) begin
            ok_r <= 1'b1;
            st_r <= S_CANS;
          end else if (cupd == 16'd0) begin
            single_r[idx_r] <= 1'b0;
            used_r[idx_r]   <= 1'b0;
            wdat_r          <= 16'd0;
            st_r            <= S_CWR;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_CWR: begin
          if (fire) begin
            if (op_r == OP_CRES) begin
              used_r[idx_r]   <= 1'b1;
              single_r[idx_r] <= 1'b1;
              ok_r            <= 1'b1;
              st_r            <= S_CANS;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        S_CANS, S_GANS: begin
          if (fire) begin
            st_r <= S_IDLE;
          end
        end
        S_GCHK: begin
          if (gchk_r[row_r] == c_r) begin
            j_r  <= 4'd1;
            st_r <= S_GRD;
          end else if (row_r == ROW_LAST) begin
            row_r <= '0;
            st_r  <= (op_r == OP_GRES) ? S_GFREE : S_IDLE;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end
        S_GRD: st_r <= S_GCMP;
        S_GCMP: begin
          if (pal_rd_r != staged_r[stg_idx]) begin
            if (row_r == ROW_LAST) begin
              row_r <= '0;
              st_r  <= (op_r == OP_GRES) ? S_GFREE : S_IDLE;
            end else begin
              row_r <= row_r + RW'(1);
              st_r  <= S_GCHK;
            end
          end else if (j_r != WORD_LAST) begin
            j_r  <= j_r + 4'd1;
            st_r <= S_GRD;
          end else begin
            gcnt_r[row_r] <= gupd;
            if (op_r == OP_GRES) begin
              ok_r <= 1'b1;
              st_r <= S_GANS;
            end else if (gupd == 8'd0) begin
              gchk_r[row_r] <= 7'd0;
              j_r           <= 4'd1;
              st_r          <= S_GWR;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        S_GFREE: begin
          if (used_r[gbase +: 15] == 15'd0) begin
            gchk_r[row_r] <= c_r;
            gcnt_r[row_r] <= 8'd1;
            j_r           <= 4'd1;
            st_r          <= S_GWR;
          end else if (row_r == ROW_LAST) begin
            ok_r <= 1'b0;
            st_r <= S_GANS;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end
        S_GWR: begin
          if (fire) begin
            used_r[gaddr] <= (op_r == OP_GRES);
            if (j_r == WORD_LAST) begin
              ok_r <= 1'b1;
              st_r <= (op_r == OP_GRES) ? S_GANS : S_IDLE;
            end else begin
              j_r <= j_r + 4'd1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/refcounted_palette_slot_allocator.sv @@
// Reference-counted palette slot allocator.
// Input queue: push/full with in_item (func, color, position); a transaction
// is taken when push is high and full is low. Result queue: empty/pop with
// out_item (kind, ok, index, data, last); the oldest result is shown while
// empty is low and leaves when pop is high.
// A front end filters and queues up to two commands; the back end runs one
// command at a time against a palette memory with one read and one write
// port, a count memory and slot flags. Staging a group word is done as the
// command is taken. A color reserve or release scans the slots from zero,
// reading and then comparing each slot, and stops at a match; a new color
// needs the full scan. A group operation checks one row per cycle, reads and
// compares up to 15 palette words in a row with a matching checksum, and then
// issues up to 15 palette writes and the answer, if any.
// Results follow in order, palette writes first and the answer, if any,
// last; last marks the final result of a transaction.
// Reset (synchronous, rst_n low) empties both queues, frees every slot but
// slot zero, clears group counts, row checksums and staged words (slot
// counts are not reset). When the receiver holds off pop, the back end stalls on
// the two-entry result queue; input is taken until the command queue fills.
// Depends on rpsa_pkg, rpsa_front, rpsa_back and rpsa_fifo.
`timescale 1ns / 1ps
module refcounted_palette_slot_allocator #(
  parameter int NUM_ROWS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rpsa_pkg::in_t  in_item,
  output logic           full,
  input  logic           pop,
  output rpsa_pkg::out_t out_item,
  output logic           empty
);
  import rpsa_pkg::*;

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;
  out_t res_item;
  logic [$bits(out_t)-1:0] res_bits;

  rpsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  rpsa_back #(.NUM_ROWS(NUM_ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  rpsa_fifo #(.W($bits(out_t))) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign out_item = out_t'(res_bits);
endmodule

@@ hdl/rpsa_checker.sv @@
// Port-level checks of the palette slot allocator, bound to the top level.
// Depends on rpsa_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "refcounted_palette_slot_allocator_defines.svh"
module rpsa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           full,
  input logic           pop,
  input rpsa_pkg::out_t out_item,
  input logic           empty
);
  import rpsa_pkg::*;

  logic is_write, is_answer;
  assign is_write  = !empty && (out_item.kind == KIND_WRITE);
  assign is_answer = !empty && (out_item.kind != KIND_WRITE);

  `RPSA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (empty && !full), "queues busy after reset")
  `RPSA_ASSERT(a_answer, is_answer |-> (out_item.last && (out_item.data == 16'd0)), "bad answer")
  `RPSA_ASSERT(a_fail_index, (is_answer && !out_item.ok) |-> (out_item.index == 8'd0), "fail index")
  `RPSA_ASSERT(a_write_ok, is_write |-> !out_item.ok, "palette write with ok set")
  `RPSA_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_item)), "result not held")
endmodule

bind refcounted_palette_slot_allocator rpsa_checker u_rpsa_checker (.*);
